### rtl/core/fmc_pkg.sv
package fmc_pkg;
  localparam int WindowBytes = 512;
  localparam int NameChars = 8;
  localparam int CountW = $clog2(WindowBytes + 1);
  localparam int LenW = $clog2(NameChars + 2);

  localparam logic [4:0] ClsEmpty    = 5'd0;
  localparam logic [4:0] ClsElf      = 5'd1;
  localparam logic [4:0] ClsSh       = 5'd2;
  localparam logic [4:0] ClsBash     = 5'd3;
  localparam logic [4:0] ClsDash     = 5'd4;
  localparam logic [4:0] ClsAwk      = 5'd5;
  localparam logic [4:0] ClsSed      = 5'd6;
  localparam logic [4:0] ClsPerl     = 5'd7;
  localparam logic [4:0] ClsPython   = 5'd8;
  localparam logic [4:0] ClsLua      = 5'd9;
  localparam logic [4:0] ClsExpect   = 5'd10;
  localparam logic [4:0] ClsMake     = 5'd11;
  localparam logic [4:0] ClsScript   = 5'd12;
  localparam logic [4:0] ClsPdf      = 5'd13;
  localparam logic [4:0] ClsGzip     = 5'd14;
  localparam logic [4:0] ClsCompress = 5'd15;
  localparam logic [4:0] ClsBzip2    = 5'd16;
  localparam logic [4:0] Cls7z       = 5'd17;
  localparam logic [4:0] ClsMz       = 5'd18;
  localparam logic [4:0] ClsTarPosix = 5'd19;
  localparam logic [4:0] ClsTarGnu   = 5'd20;
  localparam logic [4:0] ClsPng      = 5'd21;
  localparam logic [4:0] ClsJpeg     = 5'd22;
  localparam logic [4:0] ClsText     = 5'd23;
  localparam logic [4:0] ClsData     = 5'd24;

  localparam logic [1:0] PhSkip = 2'd0;
  localparam logic [1:0] PhName = 2'd1;
  localparam logic [1:0] PhDone = 2'd2;

  // snapshot of a finished file handed from front to back
  typedef struct packed {
    logic [CountW-1:0]          count;
    logic [6:0][7:0]            head;
    logic                       ustar;
    logic [7:0]                 kind;
    logic                       zero;
    logic [NameChars-1:0][7:0]  name;
    logic [LenW-1:0]            len;
  } file_snap_t;
endpackage

### rtl/core/file_magic_classifier.sv
// channel | ports                                             | direction
// in      | in_valid in_stall in_byte_value in_byte_present in_last_item | bytes in
// out     | out_valid out_stall out_class_code out_ustar_found | one code per file
// One byte transfers every cycle in which in_valid is high and in_stall is low; the
// front updates its registers in that cycle. The result of a file passes through
// the queue and then the classifier's output register. Behind a held result the
// two-entry queue takes two more finished files; once it is full, in_stall rises
// and holds every byte. Reset is synchronous, active low.
module file_magic_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_byte_present,
  input  logic       in_last_item,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_class_code,
  output logic       out_ustar_found
);
  import fmc_pkg::*;

  file_snap_t f_snap, q_snap;
  logic       f_vld, f_stl, q_vld, q_stl;

  fmc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_byte_value, .in_byte_present,
    .in_last_item, .snap_valid(f_vld), .snap_stall(f_stl), .snap(f_snap)
  );

  fmc_queue u_queue (
    .clk, .rst_n, .wr_valid(f_vld), .wr_stall(f_stl), .wr_data(f_snap),
    .rd_valid(q_vld), .rd_stall(q_stl), .rd_data(q_snap)
  );

  fmc_back u_back (
    .clk, .rst_n, .snap_valid(q_vld), .snap_stall(q_stl), .snap(q_snap),
    .out_valid, .out_stall, .out_class_code, .out_ustar_found
  );
endmodule

### rtl/core/fmc_front.sv
module fmc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte_value,
  input  logic               in_byte_present,
  input  logic               in_last_item,
  output logic               snap_valid,
  input  logic               snap_stall,
  output fmc_pkg::file_snap_t snap
);
  import fmc_pkg::*;

  logic [CountW-1:0]         cnt_r;
  logic [6:0][7:0]           head_r;
  logic                      ustar_r;
  logic [7:0]                kind_r;
  logic                      zero_r;
  logic [1:0]                ph_r;
  logic [NameChars-1:0][7:0] name_r;
  logic [LenW-1:0]           len_r;

  logic                      take, add;
  logic [7:0]                c;
  logic [CountW-1:0]         cnt_nxt;
  logic [6:0][7:0]           head_nxt;
  logic                      ustar_nxt, zero_nxt;
  logic [7:0]                kind_nxt;
  logic [1:0]                ph_nxt;
  logic [NameChars-1:0][7:0] name_nxt;
  logic [LenW-1:0]           len_nxt;
  logic [7:0]                ustar_ch;

  assign in_stall = snap_stall;
  assign take = in_valid && !in_stall;
  assign c = in_byte_value;
  assign add = in_byte_present && (cnt_r < CountW'(WindowBytes));

  always_comb begin
    unique case (cnt_r)
      CountW'(257): ustar_ch = "u";
      CountW'(258): ustar_ch = "s";
      CountW'(259): ustar_ch = "t";
      CountW'(260): ustar_ch = "a";
      default:      ustar_ch = "r";
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r; head_nxt = head_r; ustar_nxt = ustar_r; kind_nxt = kind_r;
    zero_nxt = zero_r; ph_nxt = ph_r; name_nxt = name_r; len_nxt = len_r;
    if (add) begin
      if (cnt_r < CountW'(7)) head_nxt[cnt_r[2:0]] = c;
      if (cnt_r >= CountW'(257) && cnt_r <= CountW'(261) && c != ustar_ch) ustar_nxt = 1'b0;
      if (cnt_r == CountW'(262)) kind_nxt = c;
      if (c == 8'h00) zero_nxt = 1'b1;
      if (cnt_r >= CountW'(2) && cnt_r < CountW'(WindowBytes - 1) && ph_r != PhDone) begin
        if (c == 8'h0a || c == 8'h00) begin
          ph_nxt = PhDone;
        end else if (ph_r == PhSkip && c == " ") begin
          ph_nxt = PhSkip;
        end else if (ph_r == PhName && c == " ") begin
          ph_nxt = PhDone;
        end else begin
          ph_nxt = PhName;
          if (c == "/") begin
            len_nxt = '0;
          end else begin
            if (len_r < LenW'(NameChars)) name_nxt[len_r[$clog2(NameChars)-1:0]] = c;
            if (len_r <= LenW'(NameChars)) len_nxt = len_r + LenW'(1);
          end
        end
      end
      cnt_nxt = cnt_r + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_last_item)) begin
      cnt_r <= '0; head_r <= '0; ustar_r <= 1'b1; kind_r <= '0; zero_r <= 1'b0;
      ph_r <= PhSkip; name_r <= '0; len_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_nxt; head_r <= head_nxt; ustar_r <= ustar_nxt; kind_r <= kind_nxt;
      zero_r <= zero_nxt; ph_r <= ph_nxt; name_r <= name_nxt; len_r <= len_nxt;
    end
  end

  assign snap_valid = in_valid && in_last_item;
  always_comb begin
    snap.count = cnt_nxt;
    snap.head  = head_nxt;
    snap.ustar = ustar_nxt;
    snap.kind  = kind_nxt;
    snap.zero  = zero_nxt;
    snap.name  = name_nxt;
    snap.len   = len_nxt;
  end
endmodule

### rtl/core/fmc_queue.sv
module fmc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_stall,
  input  fmc_pkg::file_snap_t wr_data,
  output logic               rd_valid,
  input  logic               rd_stall,
  output fmc_pkg::file_snap_t rd_data
);
  import fmc_pkg::*;

  file_snap_t mem_r [2];
  logic [1:0] wp_r, rp_r;
  logic       wr, rd;

  assign wr_stall = (wp_r[0] == rp_r[0]) && (wp_r[1] != rp_r[1]);
  assign rd_valid = wp_r != rp_r;
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;
  assign rd_data = mem_r[rp_r[0]];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r[0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
    end
  end
endmodule

### rtl/core/fmc_back.sv
module fmc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               snap_valid,
  output logic               snap_stall,
  input  fmc_pkg::file_snap_t snap,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_class_code,
  output logic               out_ustar_found
);
  import fmc_pkg::*;

  logic       vld_r;
  logic [4:0] cls_r;
  logic       ust_r;
  logic [4:0] cls, scls;
  logic [6:0][7:0] b;
  logic       load;

  function automatic logic name_is(input logic [NameChars-1:0][7:0] nm,
                                   input logic [LenW-1:0] ln,
                                   input logic [7*8-1:0] s, input int k);
    logic ok;
    ok = (ln == LenW'(k)) && (k <= NameChars);
    for (int i = 0; i < 7; i++)
      if (i < k && i < NameChars && nm[i] != s[(k-1-i)*8 +: 8]) ok = 1'b0;
    return ok;
  endfunction

  assign b = snap.head;

  always_comb begin
    priority if (name_is(snap.name, snap.len, 56'("sh"), 2))          scls = ClsSh;
    else if (name_is(snap.name, snap.len, 56'("bash"), 4))            scls = ClsBash;
    else if (name_is(snap.name, snap.len, 56'("dash"), 4))            scls = ClsDash;
    else if (name_is(snap.name, snap.len, 56'("awk"), 3))             scls = ClsAwk;
    else if (name_is(snap.name, snap.len, 56'("sed"), 3))             scls = ClsSed;
    else if (name_is(snap.name, snap.len, 56'("perl"), 4))            scls = ClsPerl;
    else if (name_is(snap.name, snap.len, 56'("python"), 6) ||
             name_is(snap.name, snap.len, 56'("python3"), 7))         scls = ClsPython;
    else if (name_is(snap.name, snap.len, 56'("lua"), 3))             scls = ClsLua;
    else if (name_is(snap.name, snap.len, 56'("expect"), 6))          scls = ClsExpect;
    else if (name_is(snap.name, snap.len, 56'("make"), 4) ||
             name_is(snap.name, snap.len, 56'("gmake"), 5))           scls = ClsMake;
    else                                                              scls = ClsScript;
  end

  always_comb begin
    logic n2, n3, n4, n7, tar;
    n2 = snap.count >= CountW'(2);
    n3 = snap.count >= CountW'(3);
    n4 = snap.count >= CountW'(4);
    n7 = snap.count >= CountW'(7);
    tar = (snap.count >= CountW'(263)) && snap.ustar;
    priority if (snap.count == '0) cls = ClsEmpty;
    else if (n4 && b[0] == 8'h7f && b[1] == "E" && b[2] == "L" && b[3] == "F") cls = ClsElf;
    else if (n2 && b[0] == "#" && b[1] == "!") cls = scls;
    else if (n4 && b[0] == "%" && b[1] == "P" && b[2] == "D" && b[3] == "F") cls = ClsPdf;
    else if (n2 && b[0] == 8'h1f && b[1] == 8'h8b) cls = ClsGzip;
    else if (n4 && b[0] == 8'h1f && b[1] == 8'h9d) cls = ClsCompress;
    else if (n3 && b[0] == 8'h42 && b[1] == 8'h5a && b[2] == 8'h68) cls = ClsBzip2;
    else if (n7 && ((b[0] == 8'hfd && b[1] == "7" && b[2] == "z" && b[3] == "X" &&
                     b[4] == "Z" && b[5] == 8'h00) ||
                    (b[0] == "7" && b[1] == "z" && b[2] == 8'hbc && b[3] == 8'haf &&
                     b[4] == 8'h27 && b[5] == 8'h1c))) cls = Cls7z;
    else if (n4 && b[0] == "M" && b[1] == "Z") cls = ClsMz;
    else if (tar && snap.kind == " ") cls = ClsTarPosix;
    else if (tar && snap.kind == 8'h00) cls = ClsTarGnu;
    else if (n4 && b[0] == 8'h89 && b[1] == "P" && b[2] == "N" && b[3] == "G") cls = ClsPng;
    else if (n2 && b[0] == 8'hff && b[1] == 8'hd8) cls = ClsJpeg;
    else cls = snap.zero ? ClsData : ClsText;
  end

  assign snap_stall = vld_r && out_stall;
  assign load = snap_valid && !snap_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (load) vld_r <= 1'b1;
    else if (!out_stall) vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cls_r <= cls;
      ust_r <= (snap.count >= CountW'(262)) && snap.ustar;
    end
  end

  assign out_valid = vld_r;
  assign out_class_code = cls_r;
  assign out_ustar_found = ust_r;
endmodule

### tb/sv/fmc_checker.sv
module fmc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_byte_present,
  input  logic       in_last_item,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [4:0] out_class_code,
  input  logic       out_ustar_found,
  output int         fail_count,
  output int         pending_codes
);
  timeunit 1ns;
  timeprecision 1ps;
  import fmc_pkg::*;

  typedef struct packed {
    logic [4:0] code;
    logic       ustar;
  } file_verdict_t;

  file_verdict_t verdict_q[$];

  int unsigned           nbytes;
  logic [6:0][7:0]       head;
  logic                  ustar_ok;
  logic [7:0]            kind;
  logic                  zero_hit;
  logic [1:0]            phase;
  logic [NameChars-1:0][7:0] iname;
  int unsigned           ilen;

  function automatic void clear_file();
    nbytes = 0;
    head = '0;
    ustar_ok = 1'b1;
    kind = 8'h00;
    zero_hit = 1'b0;
    phase = PhSkip;
    iname = '0;
    ilen = 0;
  endfunction

  function automatic bit name_eq(string s);
    if (s.len() != ilen || ilen > NameChars) return 1'b0;
    for (int k = 0; k < s.len(); k++)
      if (iname[k] != s[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [4:0] interp_code();
    if (name_eq("sh")) return ClsSh;
    if (name_eq("bash")) return ClsBash;
    if (name_eq("dash")) return ClsDash;
    if (name_eq("awk")) return ClsAwk;
    if (name_eq("sed")) return ClsSed;
    if (name_eq("perl")) return ClsPerl;
    if (name_eq("python") || name_eq("python3")) return ClsPython;
    if (name_eq("lua")) return ClsLua;
    if (name_eq("expect")) return ClsExpect;
    if (name_eq("make") || name_eq("gmake")) return ClsMake;
    return ClsScript;
  endfunction

  function automatic logic [4:0] file_class();
    if (nbytes == 0) return ClsEmpty;
    if (nbytes >= 4 && head[0] == 8'h7f && head[1] == "E" && head[2] == "L" &&
        head[3] == "F") return ClsElf;
    if (nbytes >= 2 && head[0] == "#" && head[1] == "!") return interp_code();
    if (nbytes >= 4 && head[0] == "%" && head[1] == "P" && head[2] == "D" &&
        head[3] == "F") return ClsPdf;
    if (nbytes >= 2 && head[0] == 8'h1f && head[1] == 8'h8b) return ClsGzip;
    if (nbytes >= 4 && head[0] == 8'h1f && head[1] == 8'h9d) return ClsCompress;
    if (nbytes >= 3 && head[0] == 8'h42 && head[1] == 8'h5a && head[2] == 8'h68)
      return ClsBzip2;
    if (nbytes >= 7 &&
        ((head[0] == 8'hfd && head[1] == "7" && head[2] == "z" && head[3] == "X" &&
          head[4] == "Z" && head[5] == 8'h00) ||
         (head[0] == "7" && head[1] == "z" && head[2] == 8'hbc && head[3] == 8'haf &&
          head[4] == 8'h27 && head[5] == 8'h1c))) return Cls7z;
    if (nbytes >= 4 && head[0] == "M" && head[1] == "Z") return ClsMz;
    if (nbytes >= 263 && ustar_ok) begin
      if (kind == " ") return ClsTarPosix;
      if (kind == 8'h00) return ClsTarGnu;
    end
    if (nbytes >= 4 && head[0] == 8'h89 && head[1] == "P" && head[2] == "N" &&
        head[3] == "G") return ClsPng;
    if (nbytes >= 2 && head[0] == 8'hff && head[1] == 8'hd8) return ClsJpeg;
    return zero_hit ? ClsData : ClsText;
  endfunction

  function automatic void parse_interp(logic [7:0] c, int unsigned pos);
    if (pos < 2 || pos >= WindowBytes - 1 || phase == PhDone) return;
    if (c == 8'h0a || c == 8'h00) begin
      phase = PhDone;
      return;
    end
    if (phase == PhSkip) begin
      if (c == " ") return;
      phase = PhName;
    end
    if (c == " ") begin
      phase = PhDone;
      return;
    end
    if (c == "/") begin
      ilen = 0;
      return;
    end
    if (ilen < NameChars) iname[ilen] = c;
    if (ilen <= NameChars) ilen++;
  endfunction

  function automatic void take_byte(logic [7:0] c, logic present, logic last);
    file_verdict_t v;
    string ustar_s;
    ustar_s = "ustar";
    if (present && nbytes < WindowBytes) begin
      if (nbytes < 7) head[nbytes] = c;
      if (nbytes >= 257 && nbytes <= 261 && c != ustar_s[nbytes - 257]) ustar_ok = 1'b0;
      if (nbytes == 262) kind = c;
      if (c == 8'h00) zero_hit = 1'b1;
      parse_interp(c, nbytes);
      nbytes++;
    end
    if (last) begin
      v.code = file_class();
      v.ustar = (nbytes >= 262) && ustar_ok;
      verdict_q.push_back(v);
      clear_file();
    end
  endfunction

  assign pending_codes = verdict_q.size();

  always @(posedge clk) begin
    file_verdict_t want;
    if (!rst_n) begin
      clear_file();
      verdict_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) take_byte(in_byte_value, in_byte_present, in_last_item);
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result transfer: class_code %0d", out_class_code);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (out_class_code !== want.code || out_ustar_found !== want.ustar)
            fail_count <= fail_count + 1;
          if (out_class_code !== want.code)
            $error("class_code: expected %0d, got %0d", want.code, out_class_code);
          if (out_ustar_found !== want.ustar)
            $error("ustar_found: expected %0d, got %0d", want.ustar, out_ustar_found);
        end
      end
    end
  end
endmodule

### tb/sv/tb_file_magic_classifier.sv
module tb_file_magic_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte_value = 8'h00;
  logic       in_byte_present = 1'b0;
  logic       in_last_item = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic [4:0] out_class_code;
  logic       out_ustar_found;
  int         fail_count;
  int         pending_codes;
  bit         feed_done = 1'b0;
  int         idle_cycles = 0;
  int         items_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  file_magic_classifier dut (.*);

  fmc_checker checker_i (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  // byte queue of the file being sent
  logic [7:0] fbytes[$];

  task automatic send_item(logic [7:0] b, logic present, logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_byte_present <= present;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // send file bytes; an end marker closes it when asked or when the file is empty, else the last byte does
  task automatic send_file(bit marker_end);
    int n;
    n = fbytes.size();
    for (int i = 0; i < n; i++)
      send_item(fbytes[i], 1'b1, !marker_end && i == n - 1);
    if (marker_end || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    fbytes.delete();
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) fbytes.push_back(s[i]);
  endtask

  task automatic pad_to(int n, bit text);
    while (fbytes.size() < n)
      fbytes.push_back(8'(text ? $urandom_range(32, 126) : $urandom_range(0, 255)));
  endtask

  task automatic tar_file(logic [7:0] kind, int n);
    pad_to(257, 1'b0);
    put_str($urandom_range(0, 5) == 0 ? "ustaR" : "ustar");
    fbytes.push_back(kind);
    pad_to(n, 1'b0);
  endtask

  function automatic string pick_interp();
    string names[15];
    names = '{"sh", "bash", "dash", "awk", "sed", "perl", "python", "python3", "lua",
              "expect", "make", "gmake", "ruby", "toolongnamex", "pytho"};
    return names[$urandom_range(0, 14)];
  endfunction

  task automatic random_file();
    string heads[12];
    int n;
    int pick;
    heads = '{"\x7fELF", "%PDF", "\x1f\x8b", "\x1f\x9d..", "BZh", "\xfd7zXZ",
              "7z\xbc\xaf\x27\x1c", "MZ..", "\x89PNG", "\xff\xd8", "", "#!"};
    n = $urandom_range(0, 24);
    case ($urandom_range(0, 4))
      0: begin
        put_str("#!");
        repeat ($urandom_range(0, 2)) put_str(" ");
        if ($urandom_range(0, 1)) put_str("/usr/bin/");
        put_str(pick_interp());
        if ($urandom_range(0, 1)) put_str($urandom_range(0, 1) ? " -x\n" : "\n");
        pad_to(n, 1'($urandom_range(0, 1)));
      end
      1: pad_to(n, 1'b1);
      2: pad_to(n, 1'b0);
      default: begin
        pick = $urandom_range(0, 11);
        put_str(heads[pick]);
        // a string drops zero bytes, so the xz signature gets its last byte here
        if (pick == 5) fbytes.push_back(8'h00);
        // truncate sometimes to probe the short-file rules
        while (fbytes.size() > 0 && $urandom_range(0, 3) == 0) void'(fbytes.pop_back());
        pad_to(n, 1'($urandom_range(0, 1)));
      end
    endcase
    send_file($urandom_range(0, 3) == 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed files
    send_file(1'b1);
    put_str("\x7fELF"); send_file(1'b0);
    put_str("\x7fEL"); send_file(1'b0);
    put_str("#!/bin/sh\n"); send_file(1'b0);
    put_str("#!  /usr/bin/python3 -u"); send_file(1'b1);
    put_str("#!"); send_file(1'b0);
    put_str("#!/usr/bin/abcdefghi"); send_file(1'b0);
    put_str("%PDF-1"); send_file(1'b0);
    put_str("\x1f\x8b"); send_file(1'b0);
    put_str("\x1f\x9d\x90"); fbytes.push_back(8'h00); send_file(1'b0);
    put_str("BZh"); send_file(1'b0);
    put_str("\xfd7zXZ"); fbytes.push_back(8'h00); fbytes.push_back(8'h00);
    send_file(1'b0);
    put_str("7z\xbc\xaf\x27\x1c"); fbytes.push_back(8'h00); send_file(1'b0);
    put_str("MZ\x90"); fbytes.push_back(8'h00); send_file(1'b0);
    put_str("\x89PNG"); send_file(1'b0);
    put_str("\xff\xd8"); send_file(1'b0);
    put_str("\xff"); fbytes.push_back(8'h00); put_str("\x80\x7f"); send_file(1'b0);
    tar_file(8'h20, 263); send_file(1'b0);
    // full window plus overflow
    tar_file(8'h00, 520); send_file(1'b1);
    while (items_sent < 1000) random_file();
    in_valid <= 1'b0;
    feed_done <= 1'b1;
  end

  // receiver: one long hold-off at the start while the sender keeps going, then random stalls
  initial begin
    int hold;
    @(posedge rst_n);
    out_stall <= 1'b1;
    for (hold = 0; hold < 300; hold++) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    wait (feed_done);
    @(posedge clk);
    while (pending_codes != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

### filelist.f
rtl/core/fmc_pkg.sv
rtl/core/fmc_front.sv
rtl/core/fmc_queue.sv
rtl/core/fmc_back.sv
rtl/core/file_magic_classifier.sv
tb/sv/fmc_checker.sv
tb/sv/tb_file_magic_classifier.sv
